// ----- hw/rtl/ptenc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptenc_pkg;

  // Fixed field widths
  localparam int WORD_W = 64;
  localparam int CFG_W  = 4;
  localparam int CNT_W  = 4;

  // Block size limits, in log2 of bits
  localparam logic [CFG_W-1:0] LOG2_MIN   = 4'd3;
  localparam logic [CFG_W-1:0] LOG2_WORD  = 4'd6;
  localparam logic [CFG_W-1:0] LOG2_RESET = 4'd10;

  // Masks selecting the low half of each butterfly span inside a word
  localparam logic [WORD_W-1:0] HALF_MASK [6] = '{
    64'h5555_5555_5555_5555, 64'h3333_3333_3333_3333,
    64'h0F0F_0F0F_0F0F_0F0F, 64'h00FF_00FF_00FF_00FF,
    64'h0000_FFFF_0000_FFFF, 64'h0000_0000_FFFF_FFFF
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_XR_A,
    ST_XR_B,
    ST_XR_C,
    ST_EMIT_RD,
    ST_EMIT_CAP
  } ptenc_state_t;

  // All six in-word butterfly stages: bit q becomes XOR of bits j subset of q
  function automatic logic [WORD_W-1:0] subset_xor64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = v;
    for (int s = 0; s < 6; s++) begin
      w = w ^ ((w & HALF_MASK[s]) << (1 << s));
    end
    return w;
  endfunction

  // Full bit reversal of a word
  function automatic logic [WORD_W-1:0] rev64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = v[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ptenc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptenc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/polar_transform_encoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Polar encoder (x = u * G_N on the bit-reversed input). Load N/64 words of u
// (one word for N below 64), one per cycle; the last beat starts the block. The
// in-word butterflies are applied as each word is written to the store; the
// stages across words then run on one shared 64-bit XOR unit over a single-read
// store: per word pair and stage, read partner (ST_XR_A), read word (ST_XR_B),
// write XOR (ST_XR_C). Coded words then leave one by one, last word flagged,
// each waiting for the output register to be free. Input is stalled
// from the last load beat until the last coded word is in the output register;
// that register frees the input side for the next block. A write to cfg_wr_en
// sets log2 N (3 to 10, clamped) and drops any partly loaded block. For N below
// 64 the coded bits sit in bits N-1:0 and the bits above are zero.

module polar_transform_encoder_core #(
  parameter int MAX_BITS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ptenc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ptenc_pkg::WORD_W-1:0]   in_data_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [ptenc_pkg::WORD_W-1:0]   out_coded_word,
  output logic                                out_last_word
);

  import ptenc_pkg::*;

  localparam int FLOOR_LOG2 = $clog2(MAX_BITS + 1) - 1;
  localparam int TOP_LOG2   = (FLOOR_LOG2 > 10) ? 10 : ((FLOOR_LOG2 < 3) ? 3 : FLOOR_LOG2);
  localparam int DEPTH      = (TOP_LOG2 > 6) ? (1 << (TOP_LOG2 - 6)) : 1;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CFG_W-1:0] TOP_N = CFG_W'(TOP_LOG2);

  ptenc_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  log2_r, log2_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [1:0]        stage_r, stage_nxt;
  logic [2:0]        pair_r, pair_nxt;
  logic [CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic [WORD_W-1:0] tmp_r, tmp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CFG_W-1:0]  n_eff;
  logic [4:0]        words_w;
  logic [CNT_W-1:0]  words_m1;
  logic              has_cross;
  logic              stage_last;
  logic              pair_last;
  logic [CNT_W-1:0]  low_mask;
  logic [CNT_W-1:0]  pair_dist;
  logic [CNT_W-1:0]  pair_idx;
  logic [CNT_W-1:0]  pair_hi;
  logic              in_beat;
  logic              load_done;
  logic              out_free;
  logic [WORD_W-1:0] rev_word;
  logic [WORD_W-1:0] emit_word;

  logic              ram_we;
  logic [CNT_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [CNT_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              cap;

  // Effective block size and derived counts
  always_comb begin
    if (log2_r < LOG2_MIN) begin
      n_eff = LOG2_MIN;
    end else if (log2_r > TOP_N) begin
      n_eff = TOP_N;
    end else begin
      n_eff = log2_r;
    end
    has_cross  = (n_eff > LOG2_WORD);
    words_w    = has_cross ? ((5'd1 << (n_eff - LOG2_WORD)) - 5'd1) : 5'd0;
    words_m1   = words_w[CNT_W-1:0];
    stage_last = ({2'b00, stage_r} == (n_eff - LOG2_WORD - 4'd1));
    pair_last  = (pair_r == words_m1[CNT_W-1:1]);
  end

  // Word pair addresses for the current cross-word stage
  always_comb begin
    pair_dist = CNT_W'(4'd1 << stage_r);
    low_mask  = pair_dist - 4'd1;
    pair_idx  = (({1'b0, pair_r} & ~low_mask) << 1) | pair_dist | ({1'b0, pair_r} & low_mask);
    pair_hi   = pair_idx ^ pair_dist;
  end

  assign in_beat   = in_valid && !in_stall;
  assign load_done = in_beat && (load_cnt_r == words_m1);
  assign out_free  = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (load_done) begin
          state_nxt = has_cross ? ST_XR_A : ST_EMIT_RD;
        end
      end
      ST_XR_A: state_nxt = ST_XR_B;
      ST_XR_B: state_nxt = ST_XR_C;
      ST_XR_C: begin
        if (pair_last && stage_last) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_XR_A;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_CAP;
        end
      end
      ST_EMIT_CAP: begin
        state_nxt = (emit_cnt_r == words_m1) ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Sequencer outputs: store port control and handshakes
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = load_cnt_r;
    ram_wdata = subset_xor64(in_data_word);
    ram_raddr = pair_hi;
    cap       = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        ram_we   = in_beat;
      end
      ST_XR_A: ram_raddr = pair_hi;
      ST_XR_B: ram_raddr = pair_idx;
      ST_XR_C: begin
        ram_we    = 1'b1;
        ram_waddr = pair_idx;
        ram_wdata = ram_rdata ^ tmp_r;
      end
      ST_EMIT_RD:  ram_raddr = words_m1 - emit_cnt_r;
      ST_EMIT_CAP: cap = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Reorder coded bits and align short blocks to bit 0
  always_comb begin
    rev_word = rev64(ram_rdata);
    case (n_eff)
      4'd3:    emit_word = rev_word >> 56;
      4'd4:    emit_word = rev_word >> 48;
      4'd5:    emit_word = rev_word >> 32;
      default: emit_word = rev_word;
    endcase
  end

  // Counters, partner word and output register
  always_comb begin
    log2_nxt      = log2_r;
    load_cnt_nxt  = load_cnt_r;
    stage_nxt     = stage_r;
    pair_nxt      = pair_r;
    emit_cnt_nxt  = emit_cnt_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;

    if (in_beat) begin
      load_cnt_nxt = (load_cnt_r == words_m1) ? '0 : load_cnt_r + 4'd1;
    end
    if (cfg_wr_en) begin
      log2_nxt     = cfg_wr_data;
      load_cnt_nxt = '0;
    end

    if (state_r == ST_XR_B) begin
      tmp_nxt = ram_rdata;
    end
    if (state_r == ST_XR_C) begin
      if (pair_last) begin
        pair_nxt  = '0;
        stage_nxt = stage_last ? 2'd0 : stage_r + 2'd1;
      end else begin
        pair_nxt = pair_r + 3'd1;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cap) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = emit_word;
      out_last_nxt  = (emit_cnt_r == words_m1);
      emit_cnt_nxt  = (emit_cnt_r == words_m1) ? '0 : emit_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      log2_r      <= LOG2_RESET;
      load_cnt_r  <= '0;
      stage_r     <= '0;
      pair_r      <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      log2_r      <= log2_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stage_r     <= stage_nxt;
      pair_r      <= pair_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tmp_r      <= tmp_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  // Word store
  ptenc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_coded_word = out_word_r;
  assign out_last_word  = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ptenc_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ptenc_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [ptenc_pkg::WORD_W-1:0] out_coded_word,
  input wire logic                         out_last_word
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coded_word)
      && $stable(out_last_word))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // While a block is still being emitted, no new input is taken
  a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> in_stall)
    else $error("input taken mid block");

  // Once a non-final word is taken, the block is still emitting
  a_emit_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> in_stall)
    else $error("input taken before final coded word");

endmodule

bind polar_transform_encoder_core ptenc_chk u_ptenc_chk (.*);

`default_nettype wire

// ----- test/tb_polar_transform_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_polar_transform_encoder_core;
  import ptenc_pkg::*;

  localparam int MAX_BITS     = 1024;
  localparam int TOP_LOG2     = ($clog2(MAX_BITS) > 10) ? 10 : $clog2(MAX_BITS);
  localparam int SETTLE       = 150;      // idle wait before size writes and at the end
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 150;
  localparam int TAIL_BEATS   = 24;
  localparam int TIMEOUT_NS   = 5_000_000;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [WORD_W-1:0]  value;
    logic               typed;
    logic [WORD_W-1:0]  word_ref;
  } stim_row_t;

  typedef struct {
    logic [WORD_W-1:0] coded;
    logic              last;
  } coded_beat_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_data_word;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_coded_word;
  logic              out_last_word;

  // Predictor state
  logic [MAX_BITS-1:0] u_vec;
  int                  loaded_words;
  logic [CFG_W-1:0]    size_reg;
  coded_beat_t         coded_q[$];

  // Driver to monitor / receiver side-band
  logic              typed_row = 1'b0;
  logic [WORD_W-1:0] typed_word = '0;
  logic              hold_off_req = 1'b0;
  logic              calm = 1'b0;

  // Tallies
  int         errors = 0;
  int         beats_in = 0;
  int         beats_out = 0;
  int         cfg_writes = 0;
  logic [10:0] size_seen = '0;

  stim_row_t directed[$];

  polar_transform_encoder_core #(
    .MAX_BITS(MAX_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_coded_word(out_coded_word),
    .out_last_word (out_last_word)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Register value to log2 N actually in force
  function automatic int clamp_log2(input logic [CFG_W-1:0] v);
    if (v < LOG2_MIN) return int'(LOG2_MIN);
    if (v > TOP_LOG2) return TOP_LOG2;
    return int'(v);
  endfunction

  function automatic int block_words(input int n);
    return (n > 6) ? (1 << (n - 6)) : 1;
  endfunction

  // Subset-XOR butterflies over the whole block, then read out in reverse order:
  // coded bit p is y[(N-1) ^ p]
  task automatic encode_block(input int n);
    logic [MAX_BITS-1:0] y;
    coded_beat_t         r;
    int                  nbits, words, s, i, k, b, p;
    nbits = 1 << n;
    words = block_words(n);
    y = u_vec;
    for (s = 0; s < n; s++) begin
      for (i = 0; i < nbits; i++) begin
        if (((i >> s) & 1) != 0) y[i] = y[i] ^ y[i ^ (1 << s)];
      end
    end
    for (k = 0; k < words; k++) begin
      r.coded = '0;
      for (b = 0; b < WORD_W; b++) begin
        p = k * WORD_W + b;
        if (p < nbits) r.coded[b] = y[(nbits - 1) ^ p];
      end
      r.last = (k == words - 1);
      coded_q.push_back(r);
    end
  endtask

  // One accepted input beat into the predictor
  task automatic absorb_beat(input logic [WORD_W-1:0] w);
    coded_beat_t r;
    int          n, nbits;
    n = clamp_log2(size_reg);
    nbits = 1 << n;
    if (nbits < WORD_W) w = w & ((64'd1 << nbits) - 64'd1);
    u_vec[loaded_words * WORD_W +: WORD_W] = w;
    loaded_words++;
    beats_in++;
    if (loaded_words < block_words(n)) return;
    loaded_words = 0;
    size_seen[n] = 1'b1;
    if (typed_row) begin
      r.coded = typed_word;
      r.last  = 1'b1;
      coded_q.push_back(r);
    end else begin
      encode_block(n);
    end
  endtask

  task automatic check_coded(input logic [WORD_W-1:0] w, input logic l);
    coded_beat_t e;
    beats_out++;
    if (coded_q.size() == 0) begin
      $error("coded beat with nothing expected: coded_word %h, last_word %b", w, l);
      errors++;
      return;
    end
    e = coded_q.pop_front();
    if (w !== e.coded) begin
      $error("coded_word: expected %h, actual %h", e.coded, w);
      errors++;
    end
    if (l !== e.last) begin
      $error("last_word: expected %b, actual %b", e.last, l);
      errors++;
    end
  endtask

  // Monitor: pre-edge values of both channels and the config port
  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg     = LOG2_RESET;
      loaded_words = 0;
    end else begin
      if (cfg_wr_en) begin
        size_reg     = cfg_wr_data;
        loaded_words = 0;
        cfg_writes++;
      end
      if (in_valid && !in_stall) absorb_beat(in_data_word);
      if (out_valid && !out_stall) check_coded(out_coded_word, out_last_word);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_u_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, valid left high
  task automatic send_beat(input logic [WORD_W-1:0] w, input logic typed,
                           input logic [WORD_W-1:0] word_ref);
    in_valid     <= 1'b1;
    in_data_word <= w;
    typed_row  = typed;
    typed_word = word_ref;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (calm || $urandom_range(0, 3) != 0) return;
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  // Size change only with the block idle; a partly loaded block is dropped
  task automatic write_size(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (coded_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_blocks(input int blocks, input int words, inout int sent);
    int i;
    for (i = 0; i < blocks * words; i++) begin
      send_beat(pick_u_word(), 1'b0, '0);
      sent++;
      sender_gap();
    end
  endtask

  task automatic add_row(input row_kind_t kind, input logic [WORD_W-1:0] value,
                         input logic typed, input logic [WORD_W-1:0] word_ref);
    stim_row_t row;
    row.kind     = kind;
    row.value    = value;
    row.typed    = typed;
    row.word_ref = word_ref;
    directed.push_back(row);
  endtask

  // Stimulus
  initial begin
    logic [CFG_W-1:0] v;
    int               sent, r, words, i, part;

    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_data_word = '0;
    sent         = 0;

    // Reset size (1024): sixteen words, extremes first
    add_row(ROW_BEAT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
    add_row(ROW_BEAT, 64'h0, 1'b0, '0);
    add_row(ROW_BEAT, 64'h1, 1'b0, '0);
    add_row(ROW_BEAT, 64'h8000_0000_0000_0000, 1'b0, '0);
    for (i = 0; i < 12; i++) add_row(ROW_BEAT, {$urandom, $urandom}, 1'b0, '0);
    // Register 0 acts as 8-bit blocks; bits above N ignored
    add_row(ROW_CFG, 64'd0, 1'b0, '0);
    add_row(ROW_BEAT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h80);
    add_row(ROW_BEAT, 64'h1, 1'b1, 64'hFF);
    // One-word block of 64
    add_row(ROW_CFG, 64'd6, 1'b0, '0);
    add_row(ROW_BEAT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000);
    add_row(ROW_BEAT, 64'h1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    // 15 clamps to 1024; three words loaded then dropped by the next write
    add_row(ROW_CFG, 64'd15, 1'b0, '0);
    for (i = 0; i < 3; i++) add_row(ROW_BEAT, {$urandom, $urandom}, 1'b0, '0);
    add_row(ROW_CFG, 64'd7, 1'b0, '0);
    add_row(ROW_BEAT, 64'hDEAD_BEEF_0123_4567, 1'b0, '0);
    add_row(ROW_BEAT, 64'h0F0F_F0F0_3C3C_C3C3, 1'b0, '0);
    add_row(ROW_CFG, 64'd5, 1'b0, '0);
    add_row(ROW_BEAT, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) begin
        write_size(directed[k].value[CFG_W-1:0]);
      end else begin
        send_beat(directed[k].value, directed[k].typed, directed[k].word_ref);
        sender_gap();
      end
    end

    // Receiver holds off while full-size blocks keep coming, then the sender waits it out
    write_size(LOG2_RESET);
    @(posedge clk);
    hold_off_req = 1'b1;
    @(negedge clk);
    for (i = 0; i < 32; i++) send_beat(pick_u_word(), 1'b0, '0);
    in_valid <= 1'b0;
    while (coded_q.size() != 0) @(negedge clk);

    // Random segments, mostly small blocks
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      r = $urandom_range(0, 19);
      if (r < 12)      v = CFG_W'($urandom_range(3, 6));
      else if (r < 15) v = CFG_W'($urandom_range(7, 8));
      else if (r < 17) v = CFG_W'($urandom_range(9, 10));
      else if (r < 18) v = CFG_W'($urandom_range(0, 2));
      else             v = CFG_W'($urandom_range(11, 15));
      write_size(v);
      words = block_words(clamp_log2(v));
      send_blocks((words >= 8) ? 1 : $urandom_range(1, 4), words, sent);
      // partial block, left for the next write to drop
      if (words > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, words - 1);
        for (i = 0; i < part; i++) begin
          send_beat(pick_u_word(), 1'b0, '0);
          sent++;
          sender_gap();
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (coded_q.size() != 0);
      end
    end

    // Tail with no idling on either side
    @(posedge clk);
    calm = 1'b1;
    @(negedge clk);
    v = CFG_W'($urandom_range(3, 7));
    write_size(v);
    words = block_words(clamp_log2(v));
    sent = 0;
    send_blocks((TAIL_BEATS + words - 1) / words, words, sent);
    in_valid <= 1'b0;

    while (coded_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d input beats, %0d coded beats and %0d size writes.",
             beats_in, beats_out, cfg_writes);
    $display("Block sizes completed (bit n set for N = 2**n): %b", size_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- polar_transform_encoder_core.f -----
hw/rtl/ptenc_pkg.sv
hw/rtl/ptenc_ram.sv
hw/rtl/polar_transform_encoder_core.sv
hw/rtl/ptenc_chk.sv
test/tb_polar_transform_encoder_core.sv
